### sv/srpt_pkg.sv
// srpt_pkg: shared types and codes for the SRPT scheduler.
// Holds the event and result transaction structs, op/status codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package srpt_pkg;

	localparam logic OP_ARRIVE   = 1'b0;
	localparam logic OP_COMPLETE = 1'b1;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_FULL   = 2'd1;
	localparam logic [1:0] STAT_NO_JOB = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [15:0] job_id;
		logic [31:0] proc_time;
		logic [31:0] current_time;
	} evt_t;

	typedef struct packed {
		logic        start_valid;
		logic        cancel_previous;
		logic [15:0] started_job_id;
		logic [32:0] completion_time;
		logic [15:0] completed_job_id;
		logic [1:0]  status;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIND,
		ST_RD_RUN,
		ST_CMP_RUN,
		ST_DECIDE,
		ST_CPL_RET,
		ST_SCAN,
		ST_START,
		ST_DONE
	} sched_state_t;

endpackage

### sv/srpt_slot_mem.sv
// srpt_slot_mem: per-slot job id and remaining-time storage.
// One write address, one read address, registered read data. No package dependency.
`timescale 1ns / 1ps

module srpt_slot_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we_id,
	input  logic          we_rem,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata_id,
	input  logic [31:0]   wdata_rem,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rd_id,
	output logic [31:0]   rd_rem
);

	logic [15:0] id_mem  [DEPTH];
	logic [31:0] rem_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we_id) begin
			id_mem[waddr] <= wdata_id;
		end
		if (we_rem) begin
			rem_mem[waddr] <= wdata_rem;
		end
	end

	always_ff @(posedge clk) begin
		rd_id  <= id_mem[raddr];
		rd_rem <= rem_mem[raddr];
	end

endmodule

### sv/srpt_preemptive_scheduler_unit.sv
// srpt_preemptive_scheduler_unit: preemptive shortest-remaining-time job scheduler.
// Depends on srpt_pkg and srpt_slot_mem.
`timescale 1ns / 1ps

// Usage
//   evt channel (evt_valid/evt_ready/evt): one transaction per event, either a job
//   arrival (id, processing time) or completion of the running job, stamped with
//   current_time. res channel (res_valid/res_ready/res): exactly one result
//   transaction per event, in order.
//   One event is handled at a time. An arrival scans the slot valid bits one per
//   cycle for the lowest free slot; if a job is running, it then weighs preemption
//   against it in ST_RD_RUN, ST_CMP_RUN and ST_DECIDE. A completion reads the
//   retired job, then sweeps all MAX_JOBS slots through the memory read port and a
//   single shared subtract/compare unit; with no running job it skips the sweep and
//   reports status STAT_NO_JOB.
//   evt_ready is high only while the sequencer is idle; a finished result sits in
//   the output register, so the next event is taken while the result waits.
//   If the receiver stalls, the following result holds in the sequencer until the
//   output register frees up; evt_ready stays low meanwhile.
//   Reset (arst_n low) empties the job table, clears the running job and the
//   start time, and drops any pending result. The slot memories need no clearing.
module srpt_preemptive_scheduler_unit #(
	parameter int MAX_JOBS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         evt_valid,
	output logic         evt_ready,
	input  srpt_pkg::evt_t evt,
	output logic         res_valid,
	input  logic         res_ready,
	output srpt_pkg::res_t res
);

	import srpt_pkg::*;

	localparam int SW = $clog2(MAX_JOBS);
	localparam int IW = $clog2(MAX_JOBS + 1);
	localparam logic [IW-1:0] IDX_LAST = IW'(MAX_JOBS - 1);
	localparam logic [IW-1:0] IDX_END  = IW'(MAX_JOBS);

	sched_state_t state_q, state_d;

	evt_t                evt_q;
	res_t                res_q;
	res_t                res_out_q;
	logic                res_valid_q;
	logic [MAX_JOBS-1:0] slot_valid_q;
	logic [SW-1:0]       running_slot_q;
	logic                running_valid_q;
	logic [31:0]         run_start_q;
	logic [IW-1:0]       idx_q;
	logic [SW-1:0]       free_q;
	logic [31:0]         elapsed_q;
	logic [31:0]         left_q;
	logic [SW-1:0]       best_q;
	logic [31:0]         best_rem_q;
	logic [15:0]         best_id_q;
	logic                best_found_q;
	logic [SW-1:0]       cmp_idx_s1;
	logic                cmp_vld_s1;

	// shared subtract/compare unit
	logic [31:0] alu_a, alu_b;
	logic [32:0] alu_diff;
	logic        alu_borrow;

	// completion-time adder
	logic [31:0] add_b;
	logic [32:0] add_sum;

	// slot memory
	logic          mem_we_id, mem_we_rem;
	logic [SW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   mem_wdata_rem;
	logic [15:0]   rd_id;
	logic [31:0]   rd_rem;

	logic [SW-1:0] idx_addr;
	logic          evt_fire;
	logic          slot_free;
	logic          take_best;
	logic          out_load;

	srpt_slot_mem #(
		.DEPTH (MAX_JOBS),
		.AW    (SW)
	) u_slot_mem (
		.clk       (clk),
		.we_id     (mem_we_id),
		.we_rem    (mem_we_rem),
		.waddr     (mem_waddr),
		.wdata_id  (evt_q.job_id),
		.wdata_rem (mem_wdata_rem),
		.raddr     (mem_raddr),
		.rd_id     (rd_id),
		.rd_rem    (rd_rem)
	);

	assign evt_ready = (state_q == ST_IDLE);
	assign evt_fire  = evt_valid && evt_ready;
	assign res_valid = res_valid_q;
	assign res       = res_out_q;

	assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
	assign alu_borrow = alu_diff[32];
	assign add_sum    = {1'b0, evt_q.current_time} + {1'b0, add_b};

	// past the last slot the scan index reads slot zero; that data is never used
	assign idx_addr  = (idx_q < IDX_END) ? idx_q[SW-1:0] : '0;
	assign slot_free = !slot_valid_q[idx_addr];
	assign take_best = cmp_vld_s1 && slot_valid_q[cmp_idx_s1] && (!best_found_q || alu_borrow);
	assign out_load  = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, unit operands and memory controls
	always_comb begin
		state_d       = state_q;
		alu_a         = rd_rem;
		alu_b         = best_rem_q;
		add_b         = evt_q.proc_time;
		mem_we_id     = 1'b0;
		mem_we_rem    = 1'b0;
		mem_waddr     = idx_addr;
		mem_wdata_rem = evt_q.proc_time;
		mem_raddr     = idx_addr;
		unique case (state_q)
			ST_IDLE: begin
				if (evt_fire) begin
					if (evt.operation == OP_ARRIVE) begin
						state_d = ST_FIND;
					end else if (running_valid_q) begin
						state_d = ST_CPL_RET;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_FIND: begin
				if (slot_free) begin
					mem_we_id  = 1'b1;
					mem_we_rem = 1'b1;
					state_d    = running_valid_q ? ST_RD_RUN : ST_DONE;
				end else if (idx_q == IDX_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_RD_RUN: begin
				mem_raddr = running_slot_q;
				alu_a     = evt_q.current_time;
				alu_b     = run_start_q;
				state_d   = ST_CMP_RUN;
			end
			ST_CMP_RUN: begin
				alu_a   = rd_rem;
				alu_b   = elapsed_q;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				alu_a         = evt_q.proc_time;
				alu_b         = left_q;
				mem_waddr     = running_slot_q;
				mem_wdata_rem = left_q;
				mem_we_rem    = alu_borrow;
				state_d       = ST_DONE;
			end
			ST_CPL_RET: begin
				mem_raddr = running_slot_q;
				state_d   = ST_SCAN;
			end
			ST_SCAN: begin
				if (idx_q == IDX_END) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				add_b   = best_rem_q;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state: table occupancy, running job, result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q    <= '0;
			running_slot_q  <= '0;
			running_valid_q <= 1'b0;
			run_start_q     <= '0;
			res_valid_q     <= 1'b0;
		end else begin
			// load a finished result, or drop the one the receiver took
			if (state_q == ST_DONE && out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_FIND: begin
					if (slot_free) begin
						slot_valid_q[idx_addr] <= 1'b1;
						// nothing runs: start the new job right away
						if (!running_valid_q) begin
							running_slot_q  <= idx_addr;
							running_valid_q <= 1'b1;
							run_start_q     <= evt_q.current_time;
						end
					end
				end
				ST_DECIDE: begin
					// preempt: the new job is strictly shorter than what is left
					if (alu_borrow) begin
						running_slot_q <= free_q;
						run_start_q    <= evt_q.current_time;
					end
				end
				ST_CPL_RET: begin
					slot_valid_q[running_slot_q] <= 1'b0;
					running_valid_q              <= 1'b0;
				end
				ST_START: begin
					if (best_found_q) begin
						running_slot_q  <= best_q;
						running_valid_q <= 1'b1;
						run_start_q     <= evt_q.current_time;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath: event capture, scan bookkeeping, result build-up
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (evt_fire) begin
					evt_q        <= evt;
					idx_q        <= '0;
					cmp_vld_s1   <= 1'b0;
					best_found_q <= 1'b0;
					if (evt.operation == OP_COMPLETE && !running_valid_q) begin
						res_q <= '{status: STAT_NO_JOB, default: '0};
					end else begin
						res_q <= '0;
					end
				end
			end
			ST_FIND: begin
				if (slot_free) begin
					free_q <= idx_addr;
					if (!running_valid_q) begin
						res_q.start_valid     <= 1'b1;
						res_q.started_job_id  <= evt_q.job_id;
						res_q.completion_time <= add_sum;
					end
				end else if (idx_q == IDX_LAST) begin
					res_q.status <= STAT_FULL;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_RD_RUN: begin
				elapsed_q <= alu_diff[31:0];
			end
			ST_CMP_RUN: begin
				// saturate the reduced remaining time at zero
				left_q <= alu_borrow ? 32'd0 : alu_diff[31:0];
			end
			ST_DECIDE: begin
				if (alu_borrow) begin
					res_q.cancel_previous <= 1'b1;
					res_q.start_valid     <= 1'b1;
					res_q.started_job_id  <= evt_q.job_id;
					res_q.completion_time <= add_sum;
				end
			end
			ST_SCAN: begin
				if (idx_q == '0) begin
					res_q.completed_job_id <= rd_id;
				end
				if (take_best) begin
					best_q       <= cmp_idx_s1;
					best_rem_q   <= rd_rem;
					best_id_q    <= rd_id;
					best_found_q <= 1'b1;
				end
				cmp_idx_s1 <= idx_addr;
				cmp_vld_s1 <= (idx_q < IDX_END);
				if (idx_q < IDX_END) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_START: begin
				if (best_found_q) begin
					res_q.start_valid     <= 1'b1;
					res_q.started_job_id  <= best_id_q;
					res_q.completion_time <= add_sum;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					res_out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_running_slot_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		running_valid_q |-> slot_valid_q[running_slot_q])
		else $error("running job points at an empty slot");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		evt_fire |=> !evt_ready)
		else $error("event taken while previous event still in work");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && !res_valid_q |=> res_valid_q)
		else $error("finished result not moved to output register");

	a_cancel_implies_start: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_out_q.cancel_previous || res_out_q.status == STAT_FULL)
		|-> (res_out_q.start_valid == res_out_q.cancel_previous))
		else $error("preemption without start, or start on dropped job");
`endif

endmodule
